// ===== rtl/cfc_pkg.sv =====
// shared types, codes and the crc-16/ccitt byte update for the frame checker
// no dependencies
package cfc_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 256;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 16;
    localparam logic [15:0] CRC_POLY        = 16'h1021;

    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_VERSION = 2'd1,
        REG_SEED    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_BAD_CRC   = 3'd5
    } status_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_CRC     = 4'b0100,
        PH_DRAIN   = 4'b1000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  frame_type;
        logic [15:0] sequence_number;
        logic [8:0]  payload_length;
        logic [8:0]  bytes_consumed;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/cfc_if.sv =====
// valid/ready channel interfaces for input bytes and results
// depends on nothing
interface cfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface cfc_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status_code;
    logic [7:0]  frame_type;
    logic [15:0] sequence_number;
    logic [8:0]  payload_length;
    logic [8:0]  bytes_consumed;

    modport source (output valid, output result_kind, output payload_byte,
                    output status_code, output frame_type, output sequence_number,
                    output payload_length, output bytes_consumed, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input status_code, input frame_type, input sequence_number,
                    input payload_length, input bytes_consumed, output ready);
endinterface

// ===== rtl/cfc_parser.sv =====
// frame parse state machine: header checks, running crc, payload count
// depends on cfc_pkg
module cfc_parser #(
    parameter int unsigned MAX_PAYLOAD = cfc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             buffer_end,
    input  logic [15:0]      frame_magic,
    input  logic [7:0]       frame_version,
    input  logic [15:0]      crc_seed,
    output logic             res_valid,
    output cfc_pkg::result_t res
);

    localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    cfc_pkg::phase_t  phase_reg, phase_next;
    logic [2:0]       hpos_reg, hpos_next;
    logic [15:0]      crc_reg, crc_next;
    cfc_pkg::status_t herr_reg, herr_next;
    logic [7:0]       type_reg, type_next;
    logic [15:0]      seq_reg, seq_next;
    logic [15:0]      len_reg, len_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [7:0]       crc_hi_reg, crc_hi_next;
    logic             crc_lo_reg, crc_lo_next;

    logic [15:0]      crc_in;
    logic [15:0]      crc_upd;
    logic [15:0]      full_len;

    assign crc_in   = (hpos_reg == 3'd0 && phase_reg == cfc_pkg::PH_HEADER) ? crc_seed : crc_reg;
    assign crc_upd  = cfc_pkg::crc16_byte(crc_in, data_byte);
    assign full_len = {len_reg[15:8], data_byte};

    always_comb
    begin
        phase_next  = phase_reg;
        hpos_next   = hpos_reg;
        crc_next    = crc_reg;
        herr_next   = herr_reg;
        type_next   = type_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        crc_hi_next = crc_hi_reg;
        crc_lo_next = crc_lo_reg;
        res_valid   = 1'b0;
        res         = '0;
        res.kind    = cfc_pkg::KIND_STATUS;

        case (phase_reg)
            cfc_pkg::PH_HEADER:
            begin
                crc_next = crc_upd;
                case (hpos_reg)
                    3'd0: herr_next = (data_byte != frame_magic[15:8]) ?
                                      cfc_pkg::ST_BAD_MAGIC : cfc_pkg::ST_OK;
                    3'd1:
                    begin
                        if (data_byte != frame_magic[7:0])
                        begin
                            herr_next = cfc_pkg::ST_BAD_MAGIC;
                        end
                    end
                    3'd2:
                    begin
                        if (herr_reg == cfc_pkg::ST_OK && data_byte != frame_version)
                        begin
                            herr_next = cfc_pkg::ST_BAD_VER;
                        end
                    end
                    3'd3: type_next = data_byte;
                    3'd4: seq_next = {data_byte, seq_reg[7:0]};
                    3'd5: seq_next = {seq_reg[15:8], data_byte};
                    3'd6: len_next = {data_byte, len_reg[7:0]};
                    default:
                    begin
                        len_next = full_len;
                        if (herr_reg == cfc_pkg::ST_OK && {1'b0, full_len} > MAX_LEN)
                        begin
                            herr_next = cfc_pkg::ST_BAD_LEN;
                        end
                    end
                endcase

                if (hpos_reg != 3'd7)
                begin
                    hpos_next = hpos_reg + 3'd1;
                    if (buffer_end)
                    begin
                        res_valid  = 1'b1;
                        res.status = cfc_pkg::ST_SHORT;
                        hpos_next  = 3'd0;
                    end
                end
                else if (herr_next != cfc_pkg::ST_OK)
                begin
                    res_valid  = 1'b1;
                    res.status = herr_next;
                    hpos_next  = 3'd0;
                    phase_next = buffer_end ? cfc_pkg::PH_HEADER : cfc_pkg::PH_DRAIN;
                end
                else if (buffer_end)
                begin
                    res_valid  = 1'b1;
                    res.status = cfc_pkg::ST_SHORT;
                    hpos_next  = 3'd0;
                end
                else
                begin
                    hpos_next   = 3'd0;
                    remain_next = full_len[LEN_W-1:0];
                    crc_lo_next = 1'b0;
                    phase_next  = (full_len == 16'd0) ? cfc_pkg::PH_CRC : cfc_pkg::PH_PAYLOAD;
                end
            end

            cfc_pkg::PH_PAYLOAD:
            begin
                crc_next  = crc_upd;
                res_valid = 1'b1;
                if (buffer_end)
                begin
                    res.status = cfc_pkg::ST_SHORT;
                    phase_next = cfc_pkg::PH_HEADER;
                end
                else
                begin
                    res.kind         = cfc_pkg::KIND_PAYLOAD;
                    res.payload_byte = data_byte;
                    remain_next      = remain_reg - LEN_W'(1);
                    if (remain_reg == LEN_W'(1))
                    begin
                        crc_lo_next = 1'b0;
                        phase_next  = cfc_pkg::PH_CRC;
                    end
                end
            end

            cfc_pkg::PH_CRC:
            begin
                if (!crc_lo_reg)
                begin
                    crc_hi_next = data_byte;
                    crc_lo_next = 1'b1;
                    if (buffer_end)
                    begin
                        res_valid  = 1'b1;
                        res.status = cfc_pkg::ST_SHORT;
                        phase_next = cfc_pkg::PH_HEADER;
                    end
                end
                else
                begin
                    res_valid  = 1'b1;
                    phase_next = buffer_end ? cfc_pkg::PH_HEADER : cfc_pkg::PH_DRAIN;
                    if ({crc_hi_reg, data_byte} == crc_reg)
                    begin
                        res.status          = cfc_pkg::ST_OK;
                        res.frame_type      = type_reg;
                        res.sequence_number = seq_reg;
                        res.payload_length  = len_reg[8:0];
                        res.bytes_consumed  = len_reg[8:0] + 9'd10;
                    end
                    else
                    begin
                        res.status = cfc_pkg::ST_BAD_CRC;
                    end
                end
            end

            cfc_pkg::PH_DRAIN:
            begin
                if (buffer_end)
                begin
                    phase_next = cfc_pkg::PH_HEADER;
                    hpos_next  = 3'd0;
                end
            end

            default:
            begin
                phase_next = cfc_pkg::PH_HEADER;
                hpos_next  = 3'd0;
            end
        endcase

        if (!accept)
        begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= cfc_pkg::PH_HEADER;
            hpos_reg   <= 3'd0;
            herr_reg   <= cfc_pkg::ST_OK;
            crc_lo_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hpos_reg   <= hpos_next;
            herr_reg   <= herr_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            crc_reg    <= crc_next;
            type_reg   <= type_next;
            seq_reg    <= seq_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            crc_hi_reg <= crc_hi_next;
        end
    end

endmodule

// ===== rtl/cfc_out_stage.sv =====
// result register between parser and output channel
// depends on cfc_pkg
module cfc_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  cfc_pkg::result_t res,
    input  logic             out_ready,
    output logic             slot_free,
    output logic             out_valid,
    output cfc_pkg::result_t out_res
);

    logic             valid_reg, valid_next;
    cfc_pkg::result_t res_reg;

    assign slot_free = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (res_valid)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

// ===== rtl/crc_frame_checker.sv =====
// top level of the length-prefixed frame checker with crc-16/ccitt
// depends on cfc_pkg, cfc_if, cfc_parser, cfc_out_stage
//
// usage
// - in_ch carries one buffer byte per request with buffer_end on the last byte
// - out_ch carries payload bytes (kind 0) as they arrive and one status per frame
// - status carries type, sequence, length and bytes consumed when the frame is ok
// - bytes after a status are dropped up to buffer_end, then a new frame starts
// - registers magic, version and crc seed are written through cfg_we/cfg_index/cfg_data
//   while the block is idle; the seed is taken at each frame's first byte
// timing
// - one byte per cycle while no result is stalled; a result shows in the cycle after its byte
// - the parse step (one byte-wide crc update plus header compare) sits between
//   the channel handshake and the result register
// - in_ch.ready drops only while a result is held and out_ch.ready is low
// reset
// - decoder returns to the header, result register empties, magic and version
//   clear to zero and the crc seed to 0xffff
module crc_frame_checker #(
    parameter int unsigned MAX_PAYLOAD = cfc_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cfc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cfc_pkg::CFG_DATA_W-1:0]  cfg_data,
    cfc_in_if.sink                          in_ch,
    cfc_out_if.source                       out_ch
);

    logic [15:0]      magic_reg;
    logic [7:0]       version_reg;
    logic [15:0]      seed_reg;
    logic             accept;
    logic             slot_free;
    logic             res_valid;
    cfc_pkg::result_t res;
    cfc_pkg::result_t out_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 16'h0000;
            version_reg <= 8'h00;
            seed_reg    <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cfc_pkg::REG_MAGIC:   magic_reg   <= cfg_data;
                cfc_pkg::REG_VERSION: version_reg <= cfg_data[7:0];
                cfc_pkg::REG_SEED:    seed_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign in_ch.ready = slot_free;
    assign accept      = in_ch.valid && slot_free;

    cfc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (in_ch.data_byte),
        .buffer_end    (in_ch.buffer_end),
        .frame_magic   (magic_reg),
        .frame_version (version_reg),
        .crc_seed      (seed_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    cfc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ch.ready),
        .slot_free (slot_free),
        .out_valid (out_ch.valid),
        .out_res   (out_res)
    );

    assign out_ch.result_kind     = out_res.kind;
    assign out_ch.payload_byte    = out_res.payload_byte;
    assign out_ch.status_code     = out_res.status;
    assign out_ch.frame_type      = out_res.frame_type;
    assign out_ch.sequence_number = out_res.sequence_number;
    assign out_ch.payload_length  = out_res.payload_length;
    assign out_ch.bytes_consumed  = out_res.bytes_consumed;

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |-> !accept)
        else $error("byte accepted while result register full and stalled");

    a_payload_no_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.result_kind == cfc_pkg::KIND_PAYLOAD)
            |-> (out_ch.status_code == cfc_pkg::ST_OK))
        else $error("payload result carries a status code");

    a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status_code != cfc_pkg::ST_OK)
            |-> (out_ch.frame_type == 8'h00 && out_ch.sequence_number == 16'h0000
                 && out_ch.bytes_consumed == 9'd0))
        else $error("failed frame status carries header fields");

    a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !$past(out_ch.valid)) |-> $past(accept))
        else $error("result appeared without an accepted byte");

endmodule

// ===== tb/crc_frame_checker_tb.sv =====
// self-checking testbench for crc_frame_checker: drives random and directed frames through
// the byte channel, predicts every payload byte and status, compares field by field
// depends on cfc_pkg, cfc_if and the crc_frame_checker rtl
module crc_frame_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_LEN       = cfc_pkg::MAX_PAYLOAD_DEF;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [cfc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cfc_pkg::CFG_DATA_W-1:0] cfg_data;

    cfc_in_if  in_ch ();
    cfc_out_if out_ch ();

    crc_frame_checker #(
        .MAX_PAYLOAD(MAX_LEN)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // register copies
    logic [15:0] exp_magic    = 16'h0000;
    logic [7:0]  exp_version  = 8'h00;
    logic [15:0] crc_seed_val = 16'hFFFF;

    // decoder state
    cfc_pkg::phase_t  dec_phase = cfc_pkg::PH_HEADER;
    int unsigned      dec_pos   = 0;
    logic [15:0]      dec_crc   = 16'hFFFF;
    cfc_pkg::status_t dec_err   = cfc_pkg::ST_OK;
    logic [7:0]       hold_type = 8'h00;
    logic [15:0]      hold_seq  = 16'h0000;
    logic [15:0]      hold_len  = 16'h0000;
    logic [15:0]      rx_crc    = 16'h0000;

    cfc_pkg::result_t decoded_results[$];
    int unsigned fail_count   = 0;
    int unsigned item_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 5;
    int unsigned hold_request = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [15:0] ccitt_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = r[15] ^ b[k];
            r  = {r[14:0], 1'b0};
            if (fb)
                r = r ^ cfc_pkg::CRC_POLY;
        end
        return r;
    endfunction

    function automatic void decoder_restart();
        dec_phase = cfc_pkg::PH_HEADER;
        dec_pos   = 0;
        dec_crc   = crc_seed_val;
        dec_err   = cfc_pkg::ST_OK;
    endfunction

    function automatic void push_status(input cfc_pkg::status_t code);
        cfc_pkg::result_t r;
        r        = '0;
        r.kind   = cfc_pkg::KIND_STATUS;
        r.status = code;
        if (code == cfc_pkg::ST_OK)
        begin
            r.frame_type      = hold_type;
            r.sequence_number = hold_seq;
            r.payload_length  = hold_len[8:0];
            r.bytes_consumed  = 9'(hold_len + 16'd10);
        end
        decoded_results.push_back(r);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        cfc_pkg::result_t r;
        case (dec_phase)
            cfc_pkg::PH_HEADER:
            begin
                dec_crc = ccitt_next((dec_pos == 0) ? crc_seed_val : dec_crc, b);
                case (dec_pos)
                    0: dec_err = (b != exp_magic[15:8]) ? cfc_pkg::ST_BAD_MAGIC : cfc_pkg::ST_OK;
                    1: if (b != exp_magic[7:0]) dec_err = cfc_pkg::ST_BAD_MAGIC;
                    2:
                    begin
                        if (dec_err == cfc_pkg::ST_OK && b != exp_version)
                            dec_err = cfc_pkg::ST_BAD_VER;
                    end
                    3: hold_type = b;
                    4: hold_seq = {b, 8'h00};
                    5: hold_seq[7:0] = b;
                    6: hold_len = {b, 8'h00};
                    default:
                    begin
                        hold_len[7:0] = b;
                        if (dec_err == cfc_pkg::ST_OK && hold_len > MAX_LEN)
                            dec_err = cfc_pkg::ST_BAD_LEN;
                    end
                endcase
                if (dec_pos < 7)
                begin
                    dec_pos++;
                    if (last)
                    begin
                        push_status(cfc_pkg::ST_SHORT);
                        decoder_restart();
                    end
                end
                else
                begin
                    dec_pos = 8;
                    if (dec_err != cfc_pkg::ST_OK)
                    begin
                        push_status(dec_err);
                        if (last)
                            decoder_restart();
                        else
                            dec_phase = cfc_pkg::PH_DRAIN;
                    end
                    else if (last)
                    begin
                        push_status(cfc_pkg::ST_SHORT);
                        decoder_restart();
                    end
                    else
                        dec_phase = (hold_len == 0) ? cfc_pkg::PH_CRC : cfc_pkg::PH_PAYLOAD;
                end
            end
            cfc_pkg::PH_PAYLOAD:
            begin
                dec_crc = ccitt_next(dec_crc, b);
                dec_pos++;
                if (last)
                begin
                    // an early end replaces the payload byte with the status
                    push_status(cfc_pkg::ST_SHORT);
                    decoder_restart();
                end
                else
                begin
                    r              = '0;
                    r.kind         = cfc_pkg::KIND_PAYLOAD;
                    r.payload_byte = b;
                    decoded_results.push_back(r);
                    if (dec_pos >= 8 + hold_len)
                        dec_phase = cfc_pkg::PH_CRC;
                end
            end
            cfc_pkg::PH_CRC:
            begin
                if (dec_pos == 8 + hold_len)
                begin
                    rx_crc = {b, 8'h00};
                    dec_pos++;
                    if (last)
                    begin
                        push_status(cfc_pkg::ST_SHORT);
                        decoder_restart();
                    end
                end
                else
                begin
                    rx_crc[7:0] = b;
                    dec_pos++;
                    push_status((rx_crc == dec_crc) ? cfc_pkg::ST_OK : cfc_pkg::ST_BAD_CRC);
                    if (last)
                        decoder_restart();
                    else
                        dec_phase = cfc_pkg::PH_DRAIN;
                end
            end
            cfc_pkg::PH_DRAIN:
            begin
                if (last)
                    decoder_restart();
            end
            default: decoder_restart();
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cfc_pkg::result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (decoded_results.size() == 0)
            begin
                $error("result with none outstanding: kind %0h status %0h",
                       out_ch.result_kind, out_ch.status_code);
                fail_count++;
            end
            else
            begin
                want = decoded_results.pop_front();
                check_field("result_kind", want.kind, out_ch.result_kind);
                check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
                check_field("status_code", want.status, out_ch.status_code);
                check_field("frame_type", want.frame_type, out_ch.frame_type);
                check_field("sequence_number", want.sequence_number, out_ch.sequence_number);
                check_field("payload_length", want.payload_length, out_ch.payload_length);
                check_field("bytes_consumed", want.bytes_consumed, out_ch.bytes_consumed);
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
            decode_byte(in_ch.data_byte, in_ch.buffer_end);
    end

    // receiver: cycles through randomly drawn stall patterns, long hold on demand
    initial
    begin
        int unsigned tick;
        int unsigned mode;
        int unsigned hold_left;
        logic [15:0] mask;
        out_ch.ready = 1'b0;
        tick         = 0;
        mode         = 0;
        hold_left    = 0;
        mask         = 16'hFFFF;
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (tick % 48 == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mask = 16'($urandom);
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= mask[tick % 16];
                    default: out_ch.ready <= ($urandom_range(0, 3) != 0);
                endcase
                tick++;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("crc_frame_checker regression: fail");
        $finish;
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.buffer_end <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        item_count++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 10);
        end
    endtask

    task automatic send_frame(input logic [15:0] magic, input logic [7:0] ver,
                              input logic [7:0] typ, input logic [15:0] seq,
                              input logic [15:0] len_field, input int unsigned body,
                              input logic [15:0] crc_xor, input int unsigned keep,
                              input int unsigned extra);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        frame_q = '{magic[15:8], magic[7:0], ver, typ, seq[15:8], seq[7:0],
                    len_field[15:8], len_field[7:0]};
        repeat (body) frame_q.push_back(8'($urandom_range(0, 255)));
        crc = crc_seed_val;
        foreach (frame_q[i])
            crc = ccitt_next(crc, frame_q[i]);
        crc = crc ^ crc_xor;
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
        if (keep != 0)
        begin
            while (frame_q.size() > keep)
                void'(frame_q.pop_back());
        end
        repeat (extra) frame_q.push_back(8'($urandom_range(0, 255)));
        foreach (frame_q[i])
            send_byte(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic send_random_frame(input bit longest);
        logic [15:0] magic;
        logic [7:0]  ver;
        logic [15:0] len_field;
        logic [15:0] crc_xor;
        int unsigned body;
        int unsigned keep;
        int unsigned extra;
        int unsigned sel;
        int unsigned fault;
        int unsigned n;
        magic   = exp_magic;
        ver     = exp_version;
        crc_xor = 16'h0000;
        keep    = 0;
        extra   = $urandom_range(0, 3);
        sel     = $urandom_range(0, 63);
        if (longest || sel == 0)
            body = MAX_LEN;
        else if (sel == 1)
            body = $urandom_range(MAX_LEN - 8, MAX_LEN - 1);
        else if (sel < 10)
            body = $urandom_range(9, 40);
        else
            body = $urandom_range(0, 8);
        len_field = 16'(body);
        fault     = longest ? 99 : $urandom_range(0, 19);
        case (fault)
            0:
            begin
                magic = magic ^ (16'(1) << $urandom_range(0, 15));
                if ($urandom_range(0, 1) != 0)
                    ver = ~ver;
                if ($urandom_range(0, 1) != 0)
                    len_field = 16'($urandom_range(MAX_LEN + 1, 65535));
                keep = 8;
            end
            1:
            begin
                ver = ver ^ (8'(1) << $urandom_range(0, 7));
                if ($urandom_range(0, 1) != 0)
                    len_field = 16'($urandom_range(MAX_LEN + 1, 65535));
                keep = 8;
            end
            2:
            begin
                len_field = 16'($urandom_range(MAX_LEN + 1, 65535));
                keep      = 8;
            end
            3: crc_xor = 16'(1) << $urandom_range(0, 15);
            4:
            begin
                keep  = $urandom_range(1, body + 9);
                extra = 0;
            end
            5:
            begin
                // noise buffer
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_byte(8'($urandom_range(0, 255)), i == n - 1);
                return;
            end
            default: ;
        endcase
        send_frame(magic, ver, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                   len_field, body, crc_xor, keep, extra);
    endtask

    task automatic run_random_frames(input int unsigned n_items);
        int unsigned target;
        target = item_count + n_items;
        send_random_frame(1'b1);
        while (item_count < target)
            send_random_frame(1'b0);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (decoded_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfc_pkg::cfg_reg_t which, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (which)
            cfc_pkg::REG_MAGIC:   exp_magic    = value;
            cfc_pkg::REG_VERSION: exp_version  = value[7:0];
            cfc_pkg::REG_SEED:    crc_seed_val = value;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic test_directed_cases();
        // buffer ends on the first byte: too short wins over bad magic
        send_byte(8'hFF, 1'b1);
        // zero length frame, crc straight after header, two leftover bytes dropped
        send_frame(exp_magic, exp_version, 8'hFF, 16'hFFFF, 16'd0, 0, 16'h0000, 0, 2);
        // bad magic beats bad version and bad length, buffer ends on the eighth byte
        send_frame(exp_magic ^ 16'h8000, ~exp_version, 8'h00, 16'h0000, 16'hFFFF, 0,
                   16'h0000, 8, 0);
        // buffer ends on a payload byte
        send_frame(exp_magic, exp_version, 8'h80, 16'h0001, 16'd1, 1, 16'h0000, 9, 0);
        wait_drained();
    endtask

    task automatic test_extreme_settings();
        write_reg(cfc_pkg::REG_MAGIC, 16'hFFFF);
        write_reg(cfc_pkg::REG_VERSION, 16'h00FF);
        write_reg(cfc_pkg::REG_SEED, 16'h0000);
        run_random_frames(400);
        wait_drained();
        write_reg(cfc_pkg::REG_MAGIC, 16'h0000);
        write_reg(cfc_pkg::REG_VERSION, 16'h0000);
        write_reg(cfc_pkg::REG_SEED, 16'hFFFF);
        run_random_frames(400);
        wait_drained();
    endtask

    task automatic test_random_settings();
        repeat (2)
        begin
            write_reg(cfc_pkg::REG_MAGIC, 16'($urandom_range(0, 65535)));
            write_reg(cfc_pkg::REG_VERSION, 16'($urandom_range(0, 255)));
            write_reg(cfc_pkg::REG_SEED, 16'($urandom_range(0, 65535)));
            run_random_frames(400);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while requests keep coming
        burst_left   = 1000;
        hold_request = 300;
        send_frame(exp_magic, exp_version, 8'h5A, 16'h1234, 16'd40, 40, 16'h0000, 0, 0);
        send_frame(exp_magic, exp_version, 8'hA5, 16'hEDCB, 16'd40, 40, 16'h0000, 0, 1);
        wait_drained();
        burst_left = 4;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.buffer_end = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = cfc_pkg::REG_MAGIC;
        cfg_data         = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed_cases();
        test_extreme_settings();
        test_random_settings();
        test_backpressure();
        wait_drained();
        if (fail_count == 0 && decoded_results.size() == 0)
            $display("crc_frame_checker regression: pass");
        else
            $display("crc_frame_checker regression: fail");
        $finish;
    end

endmodule
